>>> rtl/ffla_pkg.sv
`timescale 1ns / 1ps
// ffla_pkg: widths, lane count and the stage record shared by the lane assigner.
// No dependencies.
package ffla_pkg;

  localparam int MAX_LANES = 32;
  localparam int TIME_W    = 64;
  localparam int LANE_W    = 5;
  localparam int CNT_W     = 6;

  typedef logic [TIME_W-1:0] time_val_t;
  typedef logic [LANE_W-1:0] lane_idx_t;
  typedef logic [CNT_W-1:0]  lane_cnt_t;

  // Item as it travels along the row of cells
  typedef struct packed {
    logic      valid;
    logic      new_group;
    time_val_t start_time;
    time_val_t end_time;
    logic      found;
    lane_idx_t lane;
    lane_cnt_t cnt;
  } ffla_stage_t;

endpackage

>>> rtl/ffla_in_if.sv
`timescale 1ns / 1ps
// ffla_in_if: interval input channel, valid/ready with payload.
// Depends on ffla_pkg.
interface ffla_in_if;
  logic                   valid;
  logic                   ready;
  logic                   new_group;
  ffla_pkg::time_val_t    start_time;
  ffla_pkg::time_val_t    end_time;

  modport source (output valid, output new_group, output start_time, output end_time,
                  input ready);
  modport sink   (input valid, input new_group, input start_time, input end_time,
                  output ready);
endinterface

>>> rtl/ffla_out_if.sv
`timescale 1ns / 1ps
// ffla_out_if: lane assignment result channel, valid/ready with payload.
// Depends on ffla_pkg.
interface ffla_out_if;
  logic                   valid;
  logic                   ready;
  ffla_pkg::lane_idx_t    lane;
  ffla_pkg::lane_cnt_t    lanes_in_use;
  logic                   overflow;

  modport source (output valid, output lane, output lanes_in_use, output overflow,
                  input ready);
  modport sink   (input valid, input lane, input lanes_in_use, input overflow,
                  output ready);
endinterface

>>> rtl/ffla_cell.sv
`timescale 1ns / 1ps
// ffla_cell: one lane of the assigner; holds its last end time and open flag,
// and one pipeline stage of the item record. Depends on ffla_pkg.
module ffla_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ffla_pkg::lane_idx_t   idx,
  input  ffla_pkg::ffla_stage_t up,
  output logic                  up_ready,
  output ffla_pkg::ffla_stage_t dn,
  input  logic                  dn_ready
);
  import ffla_pkg::*;

  time_val_t   last_end;
  logic        open;
  logic        dn_valid;
  ffla_stage_t dn_data;

  logic        take;
  logic        eff_open;
  logic        claim;
  logic        open_after;

  assign up_ready   = !dn_valid || dn_ready;
  assign take       = up.valid && up_ready;
  assign eff_open   = open && !up.new_group;
  assign claim      = !up.found && (!eff_open || (last_end < up.start_time));
  assign open_after = claim || eff_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      open     <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        dn_valid <= up.valid;
      end
      if (take) begin
        open <= open_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (claim) begin
        last_end <= up.end_time;
      end
      dn_data.valid      <= 1'b1;
      dn_data.new_group  <= up.new_group;
      dn_data.start_time <= up.start_time;
      dn_data.end_time   <= up.end_time;
      dn_data.found      <= up.found || claim;
      dn_data.lane       <= claim ? idx : up.lane;
      dn_data.cnt        <= up.cnt + lane_cnt_t'(open_after);
    end
  end

  always_comb begin
    dn       = dn_data;
    dn.valid = dn_valid;
  end

endmodule

>>> rtl/first_fit_lane_assigner_unit.sv
`timescale 1ns / 1ps
// First-fit lane assigner. An interval walks a row of MAX_LANES cells in order;
// each cell owns one lane and claims an unclaimed item if its lane is closed
// or its last end precedes the item's start (MAX_LANES is 32 in the package);
// the row is fully pipelined, so one item is accepted per cycle while the output
// is not stalled; each item sees every earlier item's update to a lane it reaches.
// Ready ripples back along the row, so a stalled output only blocks the input
// once every stage holds an item. Overflow (no free lane, all lanes open) gives
// lane 0, lanes_in_use MAX_LANES and leaves all lanes untouched. No clearing pass.
// Depends on ffla_pkg, ffla_in_if, ffla_out_if, ffla_cell.
module first_fit_lane_assigner_unit (
  input  logic clk,
  input  logic rst,
  ffla_in_if.sink    intervals,
  ffla_out_if.source assignments
);
  import ffla_pkg::*;

  ffla_stage_t stage [0:MAX_LANES];
  logic        rdy   [0:MAX_LANES];

  always_comb begin
    stage[0].valid      = intervals.valid;
    stage[0].new_group  = intervals.new_group;
    stage[0].start_time = intervals.start_time;
    stage[0].end_time   = intervals.end_time;
    stage[0].found      = 1'b0;
    stage[0].lane       = '0;
    stage[0].cnt        = '0;
  end

  assign intervals.ready = rdy[0];

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_row
    ffla_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (LANE_W'(i)),
      .up       (stage[i]),
      .up_ready (rdy[i]),
      .dn       (stage[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  assign rdy[MAX_LANES]         = assignments.ready;
  assign assignments.valid        = stage[MAX_LANES].valid;
  assign assignments.lane         = stage[MAX_LANES].found ? stage[MAX_LANES].lane : '0;
  assign assignments.lanes_in_use = stage[MAX_LANES].cnt;
  assign assignments.overflow     = !stage[MAX_LANES].found;

endmodule
